// ----- rtl/core/fwipi_pkg.sv -----
// Shared types and constants of the four-wheel incremental PI drive.
// No dependencies; used by the lanes, the merge stage and the top level.
package fwipi_pkg;

  localparam int SPEED_W      = 12;
  localparam int NUM_WHEEL_IN = 4;
  localparam int IN_DATA_W    = 2 * NUM_WHEEL_IN * SPEED_W;
  localparam int DUTY_W       = 15;
  localparam int OUT_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 15;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [SPEED_W:0]   err_t;
  typedef logic signed [SPEED_W+1:0] diff_t;
  typedef logic signed [15:0]        acc_t;
  typedef logic [7:0]                gain_t;
  typedef logic [14:0]               limit_t;
  typedef logic [DUTY_W-1:0]         duty_t;
  typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;

  localparam cfg_index_t REG_GAIN_P           = 2'd0;
  localparam cfg_index_t REG_GAIN_I           = 2'd1;
  localparam cfg_index_t REG_INTEGRATOR_LIMIT = 2'd2;
  localparam cfg_index_t REG_OUTPUT_LIMIT     = 2'd3;

  localparam gain_t  GAIN_P_RST           = 8'd10;
  localparam gain_t  GAIN_I_RST           = 8'd10;
  localparam limit_t INTEGRATOR_LIMIT_RST = 15'd7200;
  localparam limit_t OUTPUT_LIMIT_RST     = 15'd6900;

  typedef struct packed {
    logic take_in;
    logic take_mul;
    logic take_acc;
  } lane_ctl_t;

endpackage

// ----- rtl/core/fwipi_lane.sv -----
// One wheel controller lane: error, error change, products, clamped accumulator.
// Depends on fwipi_pkg.
module fwipi_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  fwipi_pkg::lane_ctl_t ctl,
  input  fwipi_pkg::speed_t   speed,
  input  fwipi_pkg::speed_t   target,
  input  logic                run,
  input  fwipi_pkg::gain_t    gain_p,
  input  fwipi_pkg::gain_t    gain_i,
  input  fwipi_pkg::limit_t   integrator_limit,
  output fwipi_pkg::acc_t     acc
);
  import fwipi_pkg::*;

  err_t                prev_err_r;
  err_t                err_r;
  err_t                err_nxt;
  diff_t               diff_r;
  diff_t               diff_nxt;
  logic signed [22:0]  prod_p_nxt;
  logic signed [22:0]  prod_p_r;
  logic signed [21:0]  prod_i_nxt;
  logic signed [21:0]  prod_i_r;
  logic signed [24:0]  sum;
  logic signed [24:0]  lim;
  logic signed [24:0]  clamped;
  acc_t                acc_r;
  acc_t                acc_nxt;

  assign err_nxt  = {speed[SPEED_W-1], speed}
                  - (run ? {target[SPEED_W-1], target} : err_t'(0));
  assign diff_nxt = {err_nxt[SPEED_W], err_nxt} - {prev_err_r[SPEED_W], prev_err_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (ctl.take_in) begin
      prev_err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      err_r  <= err_nxt;
      diff_r <= diff_nxt;
    end
  end

  assign prod_p_nxt = $signed({1'b0, gain_p}) * diff_r;
  assign prod_i_nxt = $signed({1'b0, gain_i}) * err_r;

  always_ff @(posedge clk) begin
    if (ctl.take_mul) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
    end
  end

  assign sum = 25'(acc_r) + 25'(prod_p_r) + 25'(prod_i_r);
  assign lim = $signed({10'b0, integrator_limit});

  always_comb begin
    if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
    acc_nxt = clamped[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.take_acc) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- rtl/core/fwipi_merge.sv -----
// Merge stage: clip each wheel drive, split into duty and direction, map to channels.
// Depends on fwipi_pkg; holds the output word register.
module fwipi_merge (
  input  logic                clk,
  input  fwipi_pkg::acc_t     wheel_acc [fwipi_pkg::NUM_WHEEL_IN],
  input  fwipi_pkg::limit_t   output_limit,
  input  logic                load,
  output logic [fwipi_pkg::OUT_DATA_W-1:0] tdata
);
  import fwipi_pkg::*;

  acc_t                  lim;
  acc_t                  drive [NUM_WHEEL_IN];
  duty_t                 mag [NUM_WHEEL_IN];
  logic [NUM_WHEEL_IN-1:0] neg;
  logic [NUM_WHEEL_IN-1:0] pos;
  logic [OUT_DATA_W-1:0] tdata_nxt;
  logic [OUT_DATA_W-1:0] tdata_r;

  assign lim = $signed({1'b0, output_limit});

  always_comb begin
    for (int w = 0; w < NUM_WHEEL_IN; w++) begin
      if (wheel_acc[w] > lim) begin
        drive[w] = lim;
      end else if (wheel_acc[w] < -lim) begin
        drive[w] = -lim;
      end else begin
        drive[w] = wheel_acc[w];
      end
      neg[w] = drive[w] < 0;
      pos[w] = drive[w] > 0;
      mag[w] = neg[w] ? 15'(-drive[w]) : drive[w][DUTY_W-1:0];
    end
  end

  // wheels A, B, C, D sit at 0..3; channels 1..4 take B, A, D, C
  assign tdata_nxt = {pos[2], pos[3], neg[0], neg[1], mag[2], mag[3], mag[0], mag[1]};

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= tdata_nxt;
    end
  end

  assign tdata = tdata_r;

endmodule

// ----- rtl/core/four_wheel_incremental_pi_drive.sv -----
// Top level of the four-wheel incremental PI drive: config registers, stage
// control, wheel lanes and merge stage. Depends on fwipi_pkg, fwipi_lane, fwipi_merge.
//
//  channel  direction  word                                         handshake
//  in_      slave      tdata: speed_a..d, setpoint_a..d; tuser: run tvalid/tready
//  out_     master     tdata: duty_ch1..4, reverse_ch1..4           tvalid/tready
//  cfg_     slave      index 0..3, data                             valid/ready
//
//  One word per cycle sustained while out_tready allows; four register stages (error,
//  product, accumulator and output word); a stall on out_tready holds each full stage.
//  The rate is set by the per-lane accumulator add-and-clamp loop.
//  Reset clears config to its defaults and all accumulators and previous errors.
//  Each stage advances when the one after it is empty or advancing; cfg is always ready.
module four_wheel_incremental_pi_drive #(
  parameter int WHEELS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // speed_a, speed_b, speed_c, speed_d, setpoint_a, setpoint_b, setpoint_c, setpoint_d
  input  logic [fwipi_pkg::IN_DATA_W-1:0]       in_tdata,
  // run
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // duty_ch1, duty_ch2, duty_ch3, duty_ch4, reverse_ch1..reverse_ch4
  output logic [fwipi_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  fwipi_pkg::cfg_index_t                 cfg_index,
  input  logic [fwipi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fwipi_pkg::*;

  localparam int LANES = (WHEELS < NUM_WHEEL_IN) ? WHEELS : NUM_WHEEL_IN;

  gain_t     gain_p_r;
  gain_t     gain_i_r;
  limit_t    integrator_limit_r;
  limit_t    output_limit_r;
  logic      v1_r;
  logic      v2_r;
  logic      v3_r;
  logic      v4_r;
  logic      adv1;
  logic      adv2;
  logic      adv3;
  logic      adv4;
  lane_ctl_t ctl;
  acc_t      wheel_acc [NUM_WHEEL_IN];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r           <= GAIN_P_RST;
      gain_i_r           <= GAIN_I_RST;
      integrator_limit_r <= INTEGRATOR_LIMIT_RST;
      output_limit_r     <= OUTPUT_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:           gain_p_r           <= cfg_data[7:0];
        REG_GAIN_I:           gain_i_r           <= cfg_data[7:0];
        REG_INTEGRATOR_LIMIT: integrator_limit_r <= cfg_data;
        REG_OUTPUT_LIMIT:     output_limit_r     <= cfg_data;
        default:              ;
      endcase
    end
  end

  assign adv4      = !v4_r || out_tready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  assign ctl.take_in  = in_tvalid && adv1;
  assign ctl.take_mul = v1_r && adv2;
  assign ctl.take_acc = v2_r && adv3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  assign out_tvalid = v4_r;

  for (genvar w = 0; w < NUM_WHEEL_IN; w++) begin : g_wheel
    if (w < LANES) begin : g_lane
      fwipi_lane u_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .speed            (in_tdata[w*SPEED_W +: SPEED_W]),
        .target           (in_tdata[(NUM_WHEEL_IN+w)*SPEED_W +: SPEED_W]),
        .run              (in_tuser),
        .gain_p           (gain_p_r),
        .gain_i           (gain_i_r),
        .integrator_limit (integrator_limit_r),
        .acc              (wheel_acc[w])
      );
    end else begin : g_idle
      assign wheel_acc[w] = '0;
    end
  end

  fwipi_merge u_merge (
    .clk          (clk),
    .wheel_acc    (wheel_acc),
    .output_limit (output_limit_r),
    .load         (v3_r && adv4),
    .tdata        (out_tdata)
  );

endmodule
